// File: sv/first_fit_heap_allocator_macros.svh
// Assertion macros used by the allocator control source.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FFHA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, checked outside reset.
`define FFHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// File: sv/ffha_pkg.sv
`default_nettype none
package ffha_pkg;

    localparam int ADDR_BITS    = 12;
    localparam int HEADER_UNITS = 4;
    localparam int DEPTH        = 1 << ADDR_BITS;

    localparam int A_W = ADDR_BITS;
    localparam int S_W = ADDR_BITS + 1;
    // Width for address sums; never narrower than the configuration fields.
    localparam int XW  = (ADDR_BITS + 2 > 14) ? ADDR_BITS + 2 : 14;

    localparam int BEGIN_W = 12;
    localparam int END_W   = 13;
    localparam int SIZE_W  = 12;
    localparam int BADDR_W = 12;
    localparam int GRANT_W = 12;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_RELEASED  = 2'd2;

    localparam logic CFG_HEAP_BEGIN = 1'b0;
    localparam logic CFG_HEAP_END   = 1'b1;

    typedef struct packed {
        logic               command;
        logic [SIZE_W-1:0]  request_size;
        logic [BADDR_W-1:0] block_address;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [GRANT_W-1:0] granted_address;
    } t_out_item;

    typedef struct packed {
        logic           valid;
        logic           free;
        logic [S_W-1:0] size;
        logic [A_W-1:0] prev;
    } t_hdr;

    localparam int HDR_W = $bits(t_hdr);

    typedef struct packed {
        logic [XW-1:0] heap_begin;
        logic [XW-1:0] heap_end;   // already clipped to the storage depth
    } t_heap_cfg;

    typedef struct packed {
        logic accept;
        logic cfg_write;
        logic out_free;
    } t_ctl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_sts;

endpackage
`default_nettype wire

// File: sv/ffha_ram.sv
`default_nettype none
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: sv/ffha_ctrl.sv
`default_nettype none
module ffha_ctrl
    import ffha_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_ctl      i_ctl,
    input  wire t_heap_cfg i_cfg,
    input  wire t_in_item  i_item,
    output t_sts           o_sts,
    output t_out_item      o_res
);

`include "first_fit_heap_allocator_macros.svh"

    typedef enum logic [15:0] {
        S_CLEAR = 16'h0001, S_INIT  = 16'h0002, S_IDLE = 16'h0004, S_ARD  = 16'h0008,
        S_AEV   = 16'h0010, S_APREV = 16'h0020, S_AHDR = 16'h0040, S_RBEG = 16'h0080,
        S_R1    = 16'h0100, S_R2    = 16'h0200, S_R3   = 16'h0400, S_R4   = 16'h0800,
        S_R5    = 16'h1000, S_R6    = 16'h2000, S_R7   = 16'h4000, S_DONE = 16'h8000
    } t_state;

    localparam logic [XW-1:0] HDR_X = XW'(HEADER_UNITS);

    t_state         r_state, n_state;
    logic [A_W-1:0] r_cnt, n_cnt;
    logic [XW-1:0]  r_a, n_a;
    logic [S_W-1:0] r_steps, n_steps;
    logic [XW-1:0]  r_sz, n_sz;
    logic [XW-1:0]  r_baddr, n_baddr;
    logic [XW-1:0]  r_it, n_it;
    logic [XW-1:0]  r_nn, n_nn;
    logic [XW-1:0]  r_p, n_p;
    t_hdr           r_hi, n_hi;
    t_out_item      r_res, n_res;

    logic           we, re;
    logic [A_W-1:0] waddr, raddr;
    t_hdr           wdata, rd;
    logic [HDR_W-1:0] rdata_raw;

    logic [XW-1:0]  rsize_x, after_x, split_x;

    function automatic logic in_heap(input logic [XW-1:0] x, input t_heap_cfg c);
        return (x >= c.heap_begin) && (x < c.heap_end);
    endfunction

    ffha_ram #(.WIDTH(HDR_W), .DEPTH(DEPTH)) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata_raw)
    );

    assign rd      = t_hdr'(rdata_raw);
    assign rsize_x = XW'(rd.size);
    assign after_x = r_a + rsize_x;
    assign split_x = r_a + r_sz + HDR_X;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_a     = r_a;
        n_steps = r_steps;
        n_sz    = r_sz;
        n_baddr = r_baddr;
        n_it    = r_it;
        n_nn    = r_nn;
        n_p     = r_p;
        n_hi    = r_hi;
        n_res   = r_res;
        we      = 1'b0;
        waddr   = '0;
        wdata   = '0;
        re      = 1'b0;
        raddr   = '0;

        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_cnt;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == A_W'(DEPTH - 1)) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                if (i_cfg.heap_begin < i_cfg.heap_end) begin
                    we         = 1'b1;
                    waddr      = i_cfg.heap_begin[A_W-1:0];
                    wdata.valid = 1'b1;
                    wdata.free  = 1'b1;
                    wdata.size  = S_W'(i_cfg.heap_end - i_cfg.heap_begin);
                    wdata.prev  = '0;
                end
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_ctl.accept) begin
                    n_sz    = XW'(i_item.request_size);
                    n_baddr = XW'(i_item.block_address);
                    n_res.granted_address = '0;
                    if (i_item.command == CMD_ALLOC) begin
                        n_a     = i_cfg.heap_begin;
                        n_steps = '0;
                        n_res.status = ST_NO_FIT;
                        n_state = S_ARD;
                    end else begin
                        n_res.status = ST_RELEASED;
                        n_state = S_RBEG;
                    end
                end
            end
            S_ARD: begin
                if (!(r_a < i_cfg.heap_end) || r_steps == S_W'(DEPTH)) begin
                    n_state = S_DONE;
                end else begin
                    re      = 1'b1;
                    raddr   = r_a[A_W-1:0];
                    n_state = S_AEV;
                end
            end
            S_AEV: begin
                if (!rd.valid) begin
                    n_state = S_DONE;
                end else if (rd.free && rsize_x > r_sz + 2 * HDR_X) begin
                    // Split: the tail past the request becomes a new free block.
                    we          = 1'b1;
                    waddr       = split_x[A_W-1:0];
                    wdata.valid = 1'b1;
                    wdata.free  = 1'b1;
                    wdata.size  = S_W'(rsize_x - r_sz - HDR_X);
                    wdata.prev  = r_a[A_W-1:0];
                    n_p         = split_x;
                    n_nn        = after_x;
                    n_hi        = rd;
                    n_hi.size   = S_W'(r_sz + HDR_X);
                    n_hi.free   = 1'b0;
                    n_res.status          = ST_ALLOCATED;
                    n_res.granted_address = GRANT_W'(r_a + HDR_X);
                    if (in_heap(after_x, i_cfg)) begin
                        re      = 1'b1;
                        raddr   = after_x[A_W-1:0];
                        n_state = S_APREV;
                    end else begin
                        n_state = S_AHDR;
                    end
                end else if (rd.free && rsize_x >= r_sz + HDR_X) begin
                    we         = 1'b1;
                    waddr      = r_a[A_W-1:0];
                    wdata      = rd;
                    wdata.free = 1'b0;
                    n_res.status          = ST_ALLOCATED;
                    n_res.granted_address = GRANT_W'(r_a + HDR_X);
                    n_state = S_DONE;
                end else if (rd.size == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_a     = after_x;
                    n_steps = r_steps + 1'b1;
                    n_state = S_ARD;
                end
            end
            S_APREV: begin
                if (rd.valid) begin
                    we         = 1'b1;
                    waddr      = r_nn[A_W-1:0];
                    wdata      = rd;
                    wdata.prev = r_p[A_W-1:0];
                end
                n_state = S_AHDR;
            end
            S_AHDR: begin
                we      = 1'b1;
                waddr   = r_a[A_W-1:0];
                wdata   = r_hi;
                n_state = S_DONE;
            end
            S_RBEG: begin
                n_it = r_baddr - HDR_X;
                if (r_baddr < HDR_X || !in_heap(r_baddr - HDR_X, i_cfg)) begin
                    n_state = S_DONE;
                end else begin
                    re      = 1'b1;
                    raddr   = A_W'(r_baddr - HDR_X);
                    n_state = S_R1;
                end
            end
            S_R1: begin
                if (!rd.valid) begin
                    n_state = S_DONE;
                end else begin
                    n_hi      = rd;
                    n_hi.free = 1'b1;
                    n_nn      = r_it + rsize_x;
                    if (in_heap(r_it + rsize_x, i_cfg)) begin
                        re      = 1'b1;
                        raddr   = A_W'(r_it + rsize_x);
                        n_state = S_R2;
                    end else begin
                        n_state = S_R4;
                    end
                end
            end
            S_R2: begin
                if (rd.valid && rd.free) begin
                    // Absorb the free next block.
                    n_hi.size   = S_W'(r_hi.size + rd.size);
                    we          = 1'b1;
                    waddr       = r_nn[A_W-1:0];
                    wdata       = rd;
                    wdata.valid = 1'b0;
                    n_nn        = r_nn + rsize_x;
                    if (in_heap(r_nn + rsize_x, i_cfg)) begin
                        re      = 1'b1;
                        raddr   = A_W'(r_nn + rsize_x);
                        n_state = S_R3;
                    end else begin
                        n_state = S_R4;
                    end
                end else begin
                    n_state = S_R4;
                end
            end
            S_R3: begin
                if (rd.valid) begin
                    we         = 1'b1;
                    waddr      = r_nn[A_W-1:0];
                    wdata      = rd;
                    wdata.prev = r_it[A_W-1:0];
                end
                n_state = S_R4;
            end
            S_R4: begin
                we    = 1'b1;
                waddr = r_it[A_W-1:0];
                wdata = r_hi;
                n_p   = XW'(r_hi.prev);
                if (r_it != i_cfg.heap_begin && in_heap(XW'(r_hi.prev), i_cfg)) begin
                    re      = 1'b1;
                    raddr   = r_hi.prev;
                    n_state = S_R5;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_R5: begin
                if (rd.valid && rd.free) begin
                    // The previous block absorbs this one.
                    we         = 1'b1;
                    waddr      = r_p[A_W-1:0];
                    wdata      = rd;
                    wdata.size = S_W'(rd.size + r_hi.size);
                    n_nn       = r_it + XW'(r_hi.size);
                    n_state    = S_R6;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_R6: begin
                we          = 1'b1;
                waddr       = r_it[A_W-1:0];
                wdata       = r_hi;
                wdata.valid = 1'b0;
                if (in_heap(r_nn, i_cfg)) begin
                    re      = 1'b1;
                    raddr   = r_nn[A_W-1:0];
                    n_state = S_R7;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_R7: begin
                if (rd.valid) begin
                    we         = 1'b1;
                    waddr      = r_nn[A_W-1:0];
                    wdata      = rd;
                    wdata.prev = r_p[A_W-1:0];
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_ctl.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_cnt   = '0;
            end
        endcase

        if (i_ctl.cfg_write) begin
            n_state = S_CLEAR;
            n_cnt   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_a     <= n_a;
        r_steps <= n_steps;
        r_sz    <= n_sz;
        r_baddr <= n_baddr;
        r_it    <= n_it;
        r_nn    <= n_nn;
        r_p     <= n_p;
        r_hi    <= n_hi;
        r_res   <= n_res;
    end

    assign o_sts.idle = (r_state == S_IDLE);
    assign o_sts.done = (r_state == S_DONE) && i_ctl.out_free;
    assign o_res      = r_res;

    `FFHA_ASSERT_NOW(a_no_rw_collision, i_clk, i_rst_n, we && re, waddr != raddr)
    `FFHA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n,
        o_sts.idle && i_ctl.accept && !i_ctl.cfg_write, r_state != S_IDLE)
    `FFHA_ASSERT_NEXT(a_cfg_restarts_clear, i_clk, i_rst_n,
        i_ctl.cfg_write, r_state == S_CLEAR && r_cnt == '0)

endmodule
`default_nettype wire

// File: sv/first_fit_heap_allocator.sv
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+---------------------------------
// in       | input     | i_in_valid / o_in_stall  | command, request_size, address
// out      | output    | o_out_valid / i_out_stall| status, granted_address
// cfg      | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// An allocate transaction reads one block header for each block visited on the walk,
// then grants or refuses; the single header memory port pair serves every access.
// A release transaction reads and rewrites headers through that port pair to merge.
// After reset and after every configuration write, a clearing pass writes all
// 2^ADDR_BITS header entries, one per cycle, then the initial free block is placed
// when the heap is not empty; no transaction is accepted until both are done.
// A result stalled at the output holds; the next transaction is still accepted
// and runs until its own result must be delivered.
`default_nettype none
module first_fit_heap_allocator
    import ffha_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_data,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic             i_cfg_index,
    input  wire logic [END_W-1:0] i_cfg_data
);

    // Heap bounds as written through the configuration port.
    logic [BEGIN_W-1:0] r_heap_begin;
    logic [END_W-1:0]   r_heap_end;
    logic               r_out_valid;
    t_out_item          r_out_data;

    localparam int CW = (END_W > S_W) ? END_W : S_W;

    logic      cfg_write;
    logic [CW-1:0] end_wide;
    t_heap_cfg heap_cfg;
    t_ctl      ctl;
    t_sts      sts;
    t_out_item res;

    // Configuration writes are always taken; software must issue them only while idle.
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    // The end bound is clipped to the storage depth before any use.
    assign end_wide = CW'(r_heap_end);
    assign heap_cfg.heap_begin = XW'(r_heap_begin);
    assign heap_cfg.heap_end   = (end_wide > CW'(DEPTH)) ? XW'(DEPTH) : XW'(end_wide);

    assign o_in_stall   = !sts.idle;
    assign ctl.accept   = i_in_valid && !o_in_stall;
    assign ctl.cfg_write = cfg_write;
    // The output register can take a result when empty or when its content leaves now.
    assign ctl.out_free = !r_out_valid || !i_out_stall;

    ffha_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (ctl),
        .i_cfg  (heap_cfg),
        .i_item (i_in_data),
        .o_sts  (sts),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_begin <= '0;
            r_heap_end   <= END_W'(4096);
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (i_cfg_index)
                    CFG_HEAP_BEGIN: r_heap_begin <= i_cfg_data[BEGIN_W-1:0];
                    CFG_HEAP_END:   r_heap_end   <= i_cfg_data;
                    default:        r_heap_end   <= r_heap_end;
                endcase
            end
            if (sts.done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (sts.done) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

// File: dv/first_fit_heap_allocator_tb.sv
`default_nettype none
module first_fit_heap_allocator_tb;
    import ffha_pkg::*;

    // Clock, reset and the DUT ports. Every input starts at a known value.
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_in_item         i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_item        o_out_data;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic             i_cfg_index = CFG_HEAP_BEGIN;
    logic [END_W-1:0] i_cfg_data  = '0;

    first_fit_heap_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Shadow copy of the heap: one header slot per address unit, as in the DUT.
    int unsigned heap_first;
    int unsigned heap_limit;
    bit          hdr_valid [DEPTH];
    bit          hdr_free  [DEPTH];
    int unsigned hdr_size  [DEPTH];
    int unsigned hdr_prev  [DEPTH];

    // Stimulus, expectations and bookkeeping.
    t_in_item    pending_cmds[$];
    t_out_item   expected_results[$];
    int unsigned live_blocks[$];
    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          error_count;
    int          grant_count;
    int          no_fit_count;
    int          release_count;
    int          cfg_write_count;

    // The end register is clipped to the size of the header store.
    function automatic int unsigned usable_end();
        return (heap_limit < DEPTH) ? heap_limit : DEPTH;
    endfunction

    // Rebuild the heap as a single free block when it is not empty, as reset and every register write do.
    function automatic void rebuild_heap();
        for (int i = 0; i < DEPTH; i++) begin
            hdr_valid[i] = 1'b0;
            hdr_free[i]  = 1'b0;
            hdr_size[i]  = 0;
            hdr_prev[i]  = 0;
        end
        live_blocks.delete();
        if (heap_first < usable_end()) begin
            hdr_valid[heap_first] = 1'b1;
            hdr_free[heap_first]  = 1'b1;
            hdr_size[heap_first]  = usable_end() - heap_first;
        end
    endfunction

    function automatic bit is_header(int unsigned a);
        return a >= heap_first && a < usable_end() && hdr_valid[a];
    endfunction

    // First-fit walk: split a free block with room for a second header, take a
    // block whole when it just fits, and step past blocks that are taken or too small.
    function automatic t_out_item allocate_units(int unsigned want);
        t_out_item   res;
        int unsigned a;
        int unsigned rest;
        int unsigned after;
        a = heap_first;
        res.status          = ST_NO_FIT;
        res.granted_address = '0;
        for (int steps = 0; steps < DEPTH && a < usable_end() && hdr_valid[a]; steps++) begin
            if (hdr_free[a] && hdr_size[a] > want + 2 * HEADER_UNITS) begin
                rest  = a + want + HEADER_UNITS;
                after = a + hdr_size[a];
                hdr_valid[rest] = 1'b1;
                hdr_free[rest]  = 1'b1;
                hdr_size[rest]  = hdr_size[a] - want - HEADER_UNITS;
                hdr_prev[rest]  = a;
                if (is_header(after))
                    hdr_prev[after] = rest;
                hdr_size[a] = want + HEADER_UNITS;
                hdr_free[a] = 1'b0;
                res.status          = ST_ALLOCATED;
                res.granted_address = GRANT_W'(a + HEADER_UNITS);
                return res;
            end else if (hdr_free[a] && hdr_size[a] >= want + HEADER_UNITS) begin
                hdr_free[a] = 1'b0;
                res.status          = ST_ALLOCATED;
                res.granted_address = GRANT_W'(a + HEADER_UNITS);
                return res;
            end
            if (hdr_size[a] == 0)
                break;
            a += hdr_size[a];
        end
        return res;
    endfunction

    // Free a block and merge it with a free neighbor on each side. An address
    // that is not a header inside the heap leaves everything as it was.
    function automatic void release_block(int unsigned addr);
        int unsigned blk;
        int unsigned nxt;
        int unsigned beyond;
        int unsigned prv;
        if (addr < HEADER_UNITS)
            return;
        blk = addr - HEADER_UNITS;
        if (!is_header(blk))
            return;
        hdr_free[blk] = 1'b1;
        nxt = blk + hdr_size[blk];
        if (is_header(nxt) && hdr_free[nxt]) begin
            beyond = nxt + hdr_size[nxt];
            hdr_size[blk] += hdr_size[nxt];
            hdr_valid[nxt] = 1'b0;
            if (is_header(beyond))
                hdr_prev[beyond] = blk;
        end
        if (blk != heap_first) begin
            prv = hdr_prev[blk];
            if (is_header(prv) && hdr_free[prv]) begin
                beyond = blk + hdr_size[blk];
                hdr_size[prv] += hdr_size[blk];
                hdr_valid[blk] = 1'b0;
                if (is_header(beyond))
                    hdr_prev[beyond] = prv;
            end
        end
    endfunction

    // Predict the result of one accepted transaction and keep the list of
    // live addresses current so that later releases mostly hit real blocks.
    function automatic void predict_heap_op(t_in_item cmd);
        t_out_item res;
        if (cmd.command == CMD_ALLOC) begin
            res = allocate_units(cmd.request_size);
            if (res.status == ST_ALLOCATED) begin
                live_blocks.push_back(res.granted_address);
                grant_count++;
            end else begin
                no_fit_count++;
            end
        end else begin
            release_block(cmd.block_address);
            foreach (live_blocks[i]) begin
                if (live_blocks[i] == cmd.block_address) begin
                    live_blocks.delete(i);
                    break;
                end
            end
            res.status          = ST_RELEASED;
            res.granted_address = '0;
            release_count++;
        end
        expected_results.push_back(res);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Driver: a transaction is taken at an edge where valid is high and the
    // stall is low. A stalled payload holds; otherwise the next pending command
    // goes out unless the sender chooses to idle this cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_stall) begin
            // Held transaction, nothing changes.
        end else begin
            if (i_in_valid)
                predict_heap_op(i_in_data);
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_cmds.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure on the result channel, and every delivered
    // result is checked field by field against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, status", o_out_data.status, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.status !== want.status)
                        report_mismatch("status", o_out_data.status, want.status);
                    if (o_out_data.granted_address !== want.granted_address)
                        report_mismatch("granted_address", o_out_data.granted_address,
                                        want.granted_address);
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    // Queue a command, keeping only a short backlog so that releases are drawn
    // from an up-to-date list of granted addresses.
    task automatic queue_cmd(logic cmd, int unsigned want, int unsigned addr);
        t_in_item item;
        item.command       = cmd;
        item.request_size  = SIZE_W'(want);
        item.block_address = BADDR_W'(addr);
        while (pending_cmds.size() >= 2)
            @(posedge i_clk);
        pending_cmds.push_back(item);
    endtask

    // Wait until every transaction is through and every result has arrived.
    task automatic wait_quiet();
        while (pending_cmds.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_heap_reg(logic idx, int unsigned value);
        wait_quiet();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= END_W'(value);
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_HEAP_BEGIN)
            heap_first = value & 12'hFFF;
        else
            heap_limit = value & 13'h1FFF;
        rebuild_heap();
        cfg_write_count++;
    endtask

    task automatic set_idling(int sender, int receiver);
        sender_idle_pct    = sender;
        receiver_stall_pct = receiver;
    endtask

    // Random traffic: mostly allocate/release pairs with small sizes so that the
    // chain grows long, a few large requests, and some releases of junk addresses.
    task automatic random_traffic(int count);
        int          pick;
        int unsigned want;
        for (int n = 0; n < count; n++) begin
            if (live_blocks.size() == 0 || $urandom_range(0, 99) < 55) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    want = $urandom_range(0, 40);
                else if (pick < 92)
                    want = $urandom_range(0, 400);
                else
                    want = $urandom_range(0, 4095);
                queue_cmd(CMD_ALLOC, want, $urandom_range(0, 4095));
            end else if ($urandom_range(0, 99) < 88) begin
                queue_cmd(CMD_RELEASE, $urandom_range(0, 4095),
                          live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
            end else begin
                queue_cmd(CMD_RELEASE, $urandom_range(0, 4095), $urandom_range(0, 4095));
            end
        end
    endtask

    initial begin
        heap_first  = 0;
        heap_limit  = 4096;
        error_count = 0;
        set_idling(35, 77);
        rebuild_heap();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on the reset heap of 4096 units starting at zero.
        queue_cmd(CMD_ALLOC, 0, 0);            // smallest request splits the heap
        queue_cmd(CMD_ALLOC, 4095, 4095);      // largest request never fits
        queue_cmd(CMD_RELEASE, 0, 4);          // merge back into one block
        queue_cmd(CMD_ALLOC, 4092, 0);         // takes the whole heap
        queue_cmd(CMD_ALLOC, 1, 0);            // nothing left
        queue_cmd(CMD_RELEASE, 4095, 4);
        queue_cmd(CMD_RELEASE, 0, 4);          // release of a block already free
        queue_cmd(CMD_RELEASE, 0, 0);          // address below one header
        queue_cmd(CMD_RELEASE, 0, 4095);       // not a header
        queue_cmd(CMD_RELEASE, 0, 2);
        queue_cmd(CMD_ALLOC, 100, 0);
        queue_cmd(CMD_ALLOC, 100, 0);
        queue_cmd(CMD_ALLOC, 100, 0);
        queue_cmd(CMD_RELEASE, 0, 108);        // neither neighbor free
        queue_cmd(CMD_RELEASE, 0, 4);          // merges with the next block
        queue_cmd(CMD_RELEASE, 0, 212);        // merges on both sides
        queue_cmd(CMD_ALLOC, 10, 0);
        queue_cmd(CMD_ALLOC, 10, 0);
        queue_cmd(CMD_ALLOC, 10, 0);
        queue_cmd(CMD_RELEASE, 0, 18);         // leaves a hole of 14 units
        queue_cmd(CMD_ALLOC, 20, 0);           // walks past the small hole
        queue_cmd(CMD_ALLOC, 6, 0);            // hole fits but cannot split
        random_traffic(480);

        // A window in the middle of the store, other idling pattern.
        set_idling(77, 35);
        write_heap_reg(CFG_HEAP_BEGIN, 1000);
        write_heap_reg(CFG_HEAP_END, 2000);
        random_traffic(300);

        // Last unit of the store, with the end clipped from its maximum.
        set_idling(0, 0);
        write_heap_reg(CFG_HEAP_BEGIN, 4095);
        write_heap_reg(CFG_HEAP_END, 8191);
        random_traffic(50);

        // Empty heaps: zero length, then an end below the start.
        write_heap_reg(CFG_HEAP_BEGIN, 0);
        write_heap_reg(CFG_HEAP_END, 0);
        random_traffic(40);
        write_heap_reg(CFG_HEAP_BEGIN, 2000);
        write_heap_reg(CFG_HEAP_END, 1000);
        random_traffic(30);

        // Full store again with no idling, then a small odd window.
        write_heap_reg(CFG_HEAP_BEGIN, 0);
        write_heap_reg(CFG_HEAP_END, 4096);
        random_traffic(450);
        write_heap_reg(CFG_HEAP_BEGIN, 17);
        write_heap_reg(CFG_HEAP_END, 300);
        random_traffic(300);

        wait_quiet();
        $display("Covered %0d grants, %0d no-fit answers and %0d releases",
                 grant_count, no_fit_count, release_count);
        $display("over %0d register writes, including empty and clipped heaps.",
                 cfg_write_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #200000000;
        $display("Timeout: %0d results still outstanding", expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
